### sv/imd_pkg.sv
`timescale 1ns / 1ps

package imd_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int META_WIDTH = 12;

    localparam logic [3:0] PREFIX_LEN = 4'd12;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEADER_MODE = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_METADATA_INTERVAL = 8'd1;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_BLANKS = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } imd_phase_t;

    typedef enum logic [1:0] {
        KIND_AUDIO    = 2'd0,
        KIND_META     = 2'd1,
        KIND_HDR_DONE = 2'd2
    } imd_kind_t;

    // Status from the header parser for the request being accepted.
    typedef struct packed {
        logic                   active;
        logic                   done;
        logic [COUNT_WIDTH-1:0] interval;
    } imd_hdr_status_t;

    // Characters of the header prefix "icy-metaint:".
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h69;
            4'd1:    ch = 8'h63;
            4'd2:    ch = 8'h79;
            4'd3:    ch = 8'h2D;
            4'd4:    ch = 8'h6D;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h61;
            4'd8:    ch = 8'h69;
            4'd9:    ch = 8'h6E;
            4'd10:   ch = 8'h74;
            4'd11:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### sv/imd_stream_if.sv
`timescale 1ns / 1ps

interface imd_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_stream;

    modport source (output valid, output data_byte, output first_of_stream, input ready);
    modport sink (input valid, input data_byte, input first_of_stream, output ready);
endinterface

### sv/imd_result_if.sv
`timescale 1ns / 1ps

interface imd_result_if;
    logic                            valid;
    logic                            ready;
    logic [7:0]                      out_byte;
    logic [1:0]                      out_kind;
    logic                            meta_last;
    logic [imd_pkg::COUNT_WIDTH-1:0] found_interval;

    modport source (output valid, output out_byte, output out_kind, output meta_last,
                    output found_interval, input ready);
    modport sink (input valid, input out_byte, input out_kind, input meta_last,
                  input found_interval, output ready);
endinterface

### sv/imd_cfg_if.sv
`timescale 1ns / 1ps

interface imd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [imd_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [imd_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/imd_hdr_parser.sv
`timescale 1ns / 1ps

module imd_hdr_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     first_of_stream,
    input  logic                     header_mode,
    input  logic [7:0]               data_byte,
    output imd_pkg::imd_hdr_status_t status
);

    logic                            finished_reg, finished_next;
    logic                            cr_seen_reg, cr_seen_next;
    logic                            line_started_reg, line_started_next;
    logic                            line_empty_reg, line_empty_next;
    logic [3:0]                      prefix_pos_reg, prefix_pos_next;
    imd_pkg::imd_phase_t             phase_reg, phase_next;
    logic [imd_pkg::COUNT_WIDTH-1:0] interval_reg, interval_next;

    logic                            finished_cur;
    logic                            cr_seen_cur;
    logic                            line_started_cur;
    logic                            line_empty_cur;
    logic [3:0]                      prefix_pos_cur;
    imd_pkg::imd_phase_t             phase_cur;
    logic [imd_pkg::COUNT_WIDTH-1:0] interval_cur;
    logic [imd_pkg::COUNT_WIDTH+3:0] times_ten;
    logic [3:0]                      digit;
    logic                            active;
    logic                            done;

    // A new connection clears the parse state before its first byte is handled.
    always_comb
    begin
        if (first_of_stream)
        begin
            finished_cur     = 1'b0;
            cr_seen_cur      = 1'b0;
            line_started_cur = 1'b0;
            line_empty_cur   = 1'b1;
            prefix_pos_cur   = 4'd0;
            phase_cur        = imd_pkg::PH_PREFIX;
            interval_cur     = '0;
        end
        else
        begin
            finished_cur     = finished_reg;
            cr_seen_cur      = cr_seen_reg;
            line_started_cur = line_started_reg;
            line_empty_cur   = line_empty_reg;
            prefix_pos_cur   = prefix_pos_reg;
            phase_cur        = phase_reg;
            interval_cur     = interval_reg;
        end
    end

    assign digit     = 4'(data_byte - imd_pkg::CH_ZERO);
    assign times_ten = {1'b0, interval_cur, 3'b000} + {3'b000, interval_cur, 1'b0}
                     + {(imd_pkg::COUNT_WIDTH)'(0), digit};
    assign active    = header_mode && !finished_cur;

    always_comb
    begin
        finished_next     = finished_cur;
        cr_seen_next      = cr_seen_cur;
        line_started_next = line_started_cur;
        line_empty_next   = line_empty_cur;
        prefix_pos_next   = prefix_pos_cur;
        phase_next        = phase_cur;
        interval_next     = interval_cur;
        done              = 1'b0;

        if (active)
        begin
            if (cr_seen_cur && data_byte == imd_pkg::CH_LF)
            begin
                cr_seen_next = 1'b0;
                if (line_started_cur && line_empty_cur)
                begin
                    finished_next = 1'b1;
                    done          = 1'b1;
                end
                else
                begin
                    line_started_next = 1'b1;
                    line_empty_next   = 1'b1;
                    prefix_pos_next   = 4'd0;
                    phase_next        = imd_pkg::PH_PREFIX;
                end
            end
            else if (data_byte == imd_pkg::CH_CR)
            begin
                cr_seen_next = 1'b1;
            end
            else
            begin
                cr_seen_next = 1'b0;
                // Bytes of the status line are ignored.
                if (line_started_cur)
                begin
                    line_empty_next = 1'b0;
                    case (phase_cur)
                        imd_pkg::PH_PREFIX:
                        begin
                            if (prefix_pos_cur < imd_pkg::PREFIX_LEN
                                && data_byte == imd_pkg::prefix_char(prefix_pos_cur))
                            begin
                                prefix_pos_next = prefix_pos_cur + 4'd1;
                                if (prefix_pos_cur + 4'd1 == imd_pkg::PREFIX_LEN)
                                begin
                                    phase_next    = imd_pkg::PH_BLANKS;
                                    interval_next = '0;
                                end
                            end
                            else
                            begin
                                phase_next = imd_pkg::PH_DONE;
                            end
                        end
                        imd_pkg::PH_BLANKS, imd_pkg::PH_DIGITS:
                        begin
                            if (phase_cur == imd_pkg::PH_BLANKS
                                && (data_byte == imd_pkg::CH_SPACE
                                    || data_byte == imd_pkg::CH_TAB))
                            begin
                                phase_next = imd_pkg::PH_BLANKS;
                            end
                            else if (data_byte inside {[imd_pkg::CH_ZERO:imd_pkg::CH_NINE]})
                            begin
                                phase_next = imd_pkg::PH_DIGITS;
                                if (times_ten[imd_pkg::COUNT_WIDTH+3:imd_pkg::COUNT_WIDTH]
                                    != 4'd0)
                                begin
                                    interval_next = '1;
                                end
                                else
                                begin
                                    interval_next = times_ten[imd_pkg::COUNT_WIDTH-1:0];
                                end
                            end
                            else
                            begin
                                phase_next = imd_pkg::PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_cur;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg     <= 1'b0;
            cr_seen_reg      <= 1'b0;
            line_started_reg <= 1'b0;
            line_empty_reg   <= 1'b1;
            prefix_pos_reg   <= 4'd0;
            phase_reg        <= imd_pkg::PH_PREFIX;
            interval_reg     <= '0;
        end
        else if (accept)
        begin
            finished_reg     <= finished_next;
            cr_seen_reg      <= cr_seen_next;
            line_started_reg <= line_started_next;
            line_empty_reg   <= line_empty_next;
            prefix_pos_reg   <= prefix_pos_next;
            phase_reg        <= phase_next;
            interval_reg     <= interval_next;
        end
    end

    assign status.active   = active;
    assign status.done     = done;
    assign status.interval = interval_cur;

endmodule

### sv/icy_metadata_demux_unit.sv
`timescale 1ns / 1ps

// Stream metadata demultiplexer. One stream byte is accepted per clock cycle unless a held
// result is not taken, and each request is fully handled in the cycle it is accepted: its
// result, if any, appears in the output register on the next cycle. Input is still taken
// while a finished result waits, as long as that result is being taken in the same cycle.
// Header bytes, length bytes and zero-length blocks give no result; the final LF of the
// header block gives one headers-complete result carrying the parsed interval. Register
// writes are accepted in every cycle and should be made only while the block is idle.
module icy_metadata_demux_unit (
    input  logic        clk,
    input  logic        rst_n,
    imd_stream_if.sink  stream,
    imd_result_if.source result,
    imd_cfg_if.sink     control
);

    logic                                header_mode_reg;
    logic [imd_pkg::COUNT_WIDTH-1:0]     interval_cfg_reg;

    logic [imd_pkg::COUNT_WIDTH-1:0]     audio_count_reg, audio_count_next;
    logic [imd_pkg::META_WIDTH-1:0]      meta_remaining_reg, meta_remaining_next;

    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_byte_reg;
    imd_pkg::imd_kind_t                  out_kind_reg, out_kind_next;
    logic                                meta_last_reg, meta_last_next;
    logic [imd_pkg::COUNT_WIDTH-1:0]     found_interval_reg, found_interval_next;

    logic                                accept;
    logic                                emit;
    logic [imd_pkg::COUNT_WIDTH-1:0]     audio_count_cur;
    logic [imd_pkg::META_WIDTH-1:0]      meta_remaining_cur;
    logic [imd_pkg::META_WIDTH-1:0]      meta_dec;
    logic [imd_pkg::COUNT_WIDTH-1:0]     interval;
    imd_pkg::imd_hdr_status_t            hdr;

    assign stream.ready  = !out_valid_reg || result.ready;
    assign accept        = stream.valid && stream.ready;
    assign control.ready = 1'b1;

    imd_hdr_parser u_hdr (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .first_of_stream (stream.first_of_stream),
        .header_mode     (header_mode_reg),
        .data_byte       (stream.data_byte),
        .status          (hdr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mode_reg  <= 1'b0;
            interval_cfg_reg <= '0;
        end
        else if (control.valid)
        begin
            if (control.index == imd_pkg::REG_HEADER_MODE)
            begin
                header_mode_reg <= control.data[0];
            end
            else if (control.index == imd_pkg::REG_METADATA_INTERVAL)
            begin
                interval_cfg_reg <= control.data[imd_pkg::COUNT_WIDTH-1:0];
            end
        end
    end

    assign audio_count_cur    = stream.first_of_stream ? '0 : audio_count_reg;
    assign meta_remaining_cur = stream.first_of_stream ? '0 : meta_remaining_reg;
    assign meta_dec           = meta_remaining_cur - (imd_pkg::META_WIDTH)'(1);
    assign interval           = header_mode_reg ? hdr.interval : interval_cfg_reg;

    always_comb
    begin
        audio_count_next    = audio_count_cur;
        meta_remaining_next = meta_remaining_cur;
        emit                = 1'b0;
        out_kind_next       = imd_pkg::KIND_AUDIO;
        meta_last_next      = 1'b0;
        found_interval_next = '0;

        if (hdr.active)
        begin
            if (hdr.done)
            begin
                emit                = 1'b1;
                out_kind_next       = imd_pkg::KIND_HDR_DONE;
                found_interval_next = hdr.interval;
            end
        end
        else if (meta_remaining_cur != '0)
        begin
            meta_remaining_next = meta_dec;
            emit                = 1'b1;
            out_kind_next       = imd_pkg::KIND_META;
            if (meta_dec == '0)
            begin
                audio_count_next = '0;
                meta_last_next   = 1'b1;
            end
        end
        else if (interval != '0 && audio_count_cur == interval)
        begin
            // Length byte: the block is sixteen times this many bytes long.
            meta_remaining_next = {stream.data_byte, 4'b0000};
            if (stream.data_byte == 8'd0)
            begin
                audio_count_next = '0;
            end
        end
        else
        begin
            audio_count_next = audio_count_cur + (imd_pkg::COUNT_WIDTH)'(1);
            emit             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_count_reg    <= '0;
            meta_remaining_reg <= '0;
        end
        else if (accept)
        begin
            audio_count_reg    <= audio_count_next;
            meta_remaining_reg <= meta_remaining_next;
        end
    end

    always_comb
    begin
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_byte_reg       <= (out_kind_next == imd_pkg::KIND_HDR_DONE) ? 8'd0
                                                                             : stream.data_byte;
            out_kind_reg       <= out_kind_next;
            meta_last_reg      <= meta_last_next;
            found_interval_reg <= found_interval_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_byte       = out_byte_reg;
    assign result.out_kind       = out_kind_reg;
    assign result.meta_last      = meta_last_reg;
    assign result.found_interval = found_interval_reg;

endmodule

### test/tb_icy_metadata_demux_unit.sv
`timescale 1ns / 1ps

module tb_icy_metadata_demux_unit;

    localparam int SEG_ITEMS = 135;
    localparam int SEG_COUNT = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [95:0] METAINT_TAG = "icy-metaint:";
    localparam logic [imd_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct {
        logic [7:0] data_byte;
        logic       first;
        logic       pause_mark;
    } stream_item_t;

    typedef struct {
        logic [7:0]                      out_byte;
        imd_pkg::imd_kind_t              out_kind;
        logic                            meta_last;
        logic [imd_pkg::COUNT_WIDTH-1:0] found_interval;
    } demux_out_t;

    logic clk;
    logic rst_n;

    imd_stream_if stream_bus ();
    imd_result_if result_bus ();
    imd_cfg_if    cfg_bus ();

    icy_metadata_demux_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_bus),
        .result  (result_bus),
        .control (cfg_bus)
    );

    stream_item_t pending_bytes[$];
    demux_out_t   expected_demux_out[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           item_count = 0;
    logic         begin_flag = 1'b0;

    // Shadow of the block's registers and parse state.
    logic                            cfg_header_mode;
    logic [imd_pkg::COUNT_WIDTH-1:0] cfg_interval;
    logic                            hdr_finished;
    logic                            cr_seen;
    logic                            line_started;
    logic                            line_empty;
    logic [3:0]                      tag_pos;
    imd_pkg::imd_phase_t             phase;
    logic [imd_pkg::COUNT_WIDTH-1:0] parsed_interval;
    logic [imd_pkg::COUNT_WIDTH-1:0] audio_count;
    logic [imd_pkg::META_WIDTH-1:0]  meta_left;

    function automatic void clear_stream_state();
        hdr_finished = 1'b0;
        cr_seen = 1'b0;
        line_started = 1'b0;
        line_empty = 1'b1;
        tag_pos = '0;
        phase = imd_pkg::PH_PREFIX;
        parsed_interval = '0;
        audio_count = '0;
        meta_left = '0;
    endfunction

    function automatic void expect_out(logic [7:0] b, imd_pkg::imd_kind_t kind, logic last,
                                       logic [imd_pkg::COUNT_WIDTH-1:0] iv);
        demux_out_t r;
        r.out_byte = b;
        r.out_kind = kind;
        r.meta_last = last;
        r.found_interval = iv;
        expected_demux_out.insert(expected_demux_out.size(), r);
    endfunction

    function automatic void match_header_char(logic [7:0] c);
        logic [35:0] wide;
        if (phase == imd_pkg::PH_PREFIX)
        begin
            if (tag_pos < imd_pkg::PREFIX_LEN && c == METAINT_TAG[95 - 8 * tag_pos -: 8])
            begin
                tag_pos = tag_pos + 4'd1;
                if (tag_pos == imd_pkg::PREFIX_LEN)
                begin
                    phase = imd_pkg::PH_BLANKS;
                    parsed_interval = '0;
                end
            end
            else
            begin
                phase = imd_pkg::PH_DONE;
            end
        end
        else if (phase == imd_pkg::PH_BLANKS && (c == imd_pkg::CH_SPACE || c == imd_pkg::CH_TAB))
        begin
            phase = imd_pkg::PH_BLANKS;
        end
        else if (phase == imd_pkg::PH_BLANKS || phase == imd_pkg::PH_DIGITS)
        begin
            if (c >= imd_pkg::CH_ZERO && c <= imd_pkg::CH_NINE)
            begin
                wide = {12'd0, parsed_interval};
                wide = wide * 36'd10 + {28'd0, 8'(c - imd_pkg::CH_ZERO)};
                parsed_interval = (wide > {12'd0, COUNT_MAX})
                                  ? COUNT_MAX : wide[imd_pkg::COUNT_WIDTH-1:0];
                phase = imd_pkg::PH_DIGITS;
            end
            else
            begin
                phase = imd_pkg::PH_DONE;
            end
        end
    endfunction

    // Works out what one accepted stream byte produces, if anything.
    function automatic void demux_track_byte(logic [7:0] c, logic first);
        logic [imd_pkg::COUNT_WIDTH-1:0] iv_now;
        if (first)
            clear_stream_state();
        if (cfg_header_mode && !hdr_finished)
        begin
            if (cr_seen && c == imd_pkg::CH_LF)
            begin
                cr_seen = 1'b0;
                if (line_started && line_empty)
                begin
                    hdr_finished = 1'b1;
                    expect_out(8'h00, imd_pkg::KIND_HDR_DONE, 1'b0, parsed_interval);
                end
                else
                begin
                    line_started = 1'b1;
                    line_empty = 1'b1;
                    tag_pos = '0;
                    phase = imd_pkg::PH_PREFIX;
                end
            end
            else if (c == imd_pkg::CH_CR)
            begin
                cr_seen = 1'b1;
            end
            else
            begin
                cr_seen = 1'b0;
                if (line_started)
                begin
                    line_empty = 1'b0;
                    match_header_char(c);
                end
            end
        end
        else
        begin
            iv_now = cfg_header_mode ? parsed_interval : cfg_interval;
            if (meta_left != 0)
            begin
                meta_left = meta_left - (imd_pkg::META_WIDTH)'(1);
                if (meta_left == 0)
                    audio_count = '0;
                expect_out(c, imd_pkg::KIND_META, meta_left == 0, '0);
            end
            else if (iv_now != 0 && audio_count == iv_now)
            begin
                meta_left = {c, 4'h0};
                if (meta_left == 0)
                    audio_count = '0;
            end
            else
            begin
                audio_count = audio_count + (imd_pkg::COUNT_WIDTH)'(1);
                expect_out(c, imd_pkg::KIND_AUDIO, 1'b0, '0);
            end
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stream driver: presents queued bytes and keeps the prediction in step with acceptance.
    always @(posedge clk)
    begin : stream_driver
        stream_item_t nxt;
        logic         take;
        if (rst_n)
        begin
            take = stream_bus.valid && stream_bus.ready;
            if (take)
                demux_track_byte(stream_bus.data_byte, stream_bus.first_of_stream);
            if (!stream_bus.valid || take)
            begin
                if (pending_bytes.size() > 0 && pending_bytes[0].pause_mark)
                begin
                    // Hold the stream back until every outstanding result has drained.
                    if (expected_demux_out.size() == 0)
                        void'(pending_bytes.pop_front());
                    stream_bus.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0
                         && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    stream_bus.valid <= 1'b1;
                    stream_bus.data_byte <= nxt.data_byte;
                    stream_bus.first_of_stream <= nxt.first;
                end
                else
                begin
                    stream_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        demux_out_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_demux_out.size() == 0)
                begin
                    $error("unexpected result: byte %0h kind %0d last %0b interval %0h",
                           result_bus.out_byte, result_bus.out_kind, result_bus.meta_last,
                           result_bus.found_interval);
                    error_count++;
                end
                else
                begin
                    want = expected_demux_out.pop_front();
                    compare_field("out_byte", want.out_byte, result_bus.out_byte);
                    compare_field("out_kind", want.out_kind, result_bus.out_kind);
                    compare_field("meta_last", want.meta_last, result_bus.meta_last);
                    compare_field("found_interval", want.found_interval,
                                  result_bus.found_interval);
                end
            end
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((stream_bus.valid && stream_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [imd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [imd_pkg::CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == imd_pkg::REG_HEADER_MODE)
            cfg_header_mode = value[0];
        else if (idx == imd_pkg::REG_METADATA_INTERVAL)
            cfg_interval = value[imd_pkg::COUNT_WIDTH-1:0];
        cfg_bus.valid <= 1'b0;
    endtask

    // Sampled on the falling edge so that the driver's updates at the rising edge have settled.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_bytes.size() != 0 || stream_bus.valid || expected_demux_out.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_byte(logic [7:0] b);
        stream_item_t it;
        it.data_byte = b;
        it.first = begin_flag;
        it.pause_mark = 1'b0;
        begin_flag = 1'b0;
        pending_bytes.insert(pending_bytes.size(), it);
        item_count++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_crlf();
        push_byte(imd_pkg::CH_CR);
        push_byte(imd_pkg::CH_LF);
    endfunction

    function automatic void push_pause();
        stream_item_t it;
        it.data_byte = 8'h00;
        it.first = 1'b0;
        it.pause_mark = 1'b1;
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    // Runs of iv audio bytes, then a length byte and metadata; only audio if iv is 0 or >48.
    function automatic void push_body(int iv, int upto);
        int blocks;
        while (item_count < upto)
        begin
            if (iv == 0 || iv > 48)
            begin
                push_byte(8'($urandom_range(255)));
            end
            else
            begin
                repeat (iv) push_byte(8'($urandom_range(255)));
                blocks = $urandom_range(3);
                push_byte(8'(blocks));
                repeat (blocks * 16) push_byte(8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic void push_junk_line();
        int len;
        int r;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(9);
            if (r == 0)
            begin
                push_byte(imd_pkg::CH_LF);
            end
            else if (r == 1)
            begin
                push_byte(imd_pkg::CH_CR);
                push_byte("x");
            end
            else
            begin
                push_byte(8'($urandom_range(32, 126)));
            end
        end
    endfunction

    // Builds a random but well-formed header block and returns the interval it announces.
    function automatic int push_headers();
        int val;
        int lines;
        int r;
        val = 0;
        begin_flag = 1'b1;
        repeat ($urandom_range(5))
            push_byte($urandom_range(4) == 0 ? imd_pkg::CH_LF : 8'($urandom_range(32, 126)));
        repeat ($urandom_range(1, 3)) push_byte(imd_pkg::CH_CR);
        push_byte(imd_pkg::CH_LF);
        lines = $urandom_range(3);
        for (int l = 0; l < lines; l++)
        begin
            r = $urandom_range(5);
            if (r <= 2)
            begin
                push_text("icy-metaint:");
                repeat ($urandom_range(2))
                    push_byte($urandom_range(1) ? imd_pkg::CH_SPACE : imd_pkg::CH_TAB);
                case ($urandom_range(9))
                    0: val = 0;
                    1:
                    begin
                        push_text("99999999999");
                        val = COUNT_MAX;
                    end
                    2:
                    begin
                        val = $urandom_range(1, 24);
                        push_text($sformatf("000%0d", val));
                    end
                    3:
                    begin
                        push_text("0");
                        val = 0;
                    end
                    default:
                    begin
                        val = $urandom_range(1, 24);
                        push_text($sformatf("%0d", val));
                    end
                endcase
                if ($urandom_range(3) == 0)
                    push_text($urandom_range(1) ? ";x" : " 7");
            end
            else if (r == 3)
            begin
                case ($urandom_range(2))
                    0: push_text("Icy-metaint:12");
                    1: push_text("icy-metaint 5");
                    default: push_text(" icy-metaint:7");
                endcase
            end
            else
            begin
                push_junk_line();
            end
            push_crlf();
        end
        repeat ($urandom_range(2)) push_byte(imd_pkg::CH_CR);
        push_crlf();
        return val;
    endfunction

    initial
    begin : stimulus
        int   iv;
        logic hdr_mode;
        stream_bus.valid = 1'b0;
        stream_bus.data_byte = 8'h00;
        stream_bus.first_of_stream = 1'b0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        cfg_header_mode = 1'b0;
        cfg_interval = '0;
        clear_stream_state();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: everything passes straight through.
        begin_flag = 1'b1;
        push_byte(8'h00);
        push_byte(8'hFF);
        wait_drained();

        // Register mode with a short interval; upper data bits must be ignored.
        write_reg(imd_pkg::REG_METADATA_INTERVAL, 32'hFF00_0002);
        write_reg(imd_pkg::REG_HEADER_MODE, 32'hFFFF_FFFE);
        begin_flag = 1'b1;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h7F);
        wait_drained();

        // Header block with a doubled CR on the status line and a prefix with no digits.
        write_reg(imd_pkg::REG_HEADER_MODE, 32'h1);
        begin_flag = 1'b1;
        push_text("X");
        push_byte(imd_pkg::CH_CR);
        push_crlf();
        push_text("icy-metaint:");
        push_crlf();
        push_crlf();
        push_byte(8'hC3);
        push_byte(8'h3C);
        wait_drained();

        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
            endcase
            case (seg)
                0: iv = 1;
                2, 5: iv = $urandom_range(2, 12);
                4: iv = COUNT_MAX;
                default: iv = $urandom_range(0, 40);
            endcase
            hdr_mode = !(seg == 0 || seg == 2 || seg == 4 || seg == 5);
            write_reg(imd_pkg::REG_HEADER_MODE, ($urandom & 32'hFFFF_FFFE) | hdr_mode);
            write_reg(imd_pkg::REG_METADATA_INTERVAL, ($urandom << imd_pkg::COUNT_WIDTH) | iv);
            item_count = 0;
            if (hdr_mode)
            begin
                iv = push_headers();
                push_pause();
            end
            else if (seg == 5)
            begin
                // The count left over from the long interval already exceeds the new one.
                repeat (20) push_byte(8'($urandom_range(255)));
                begin_flag = 1'b1;
            end
            else
            begin
                begin_flag = 1'b1;
            end
            push_body(iv, SEG_ITEMS / 2);
            push_pause();
            push_body(iv, SEG_ITEMS);
            if (seg == SEG_COUNT - 1)
            begin
                repeat (20)
                begin
                    begin_flag = ($urandom_range(9) == 0);
                    push_byte(8'($urandom_range(255)));
                end
            end
            wait_drained();
        end

        if (error_count == 0 && expected_demux_out.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
